/* hdl/wrc_pkg.sv */
// Package for the windowed read cache controller.
// Shared widths, operation codes and register indexes; no dependencies.
`timescale 1ns / 1ps

package wrc_pkg;

	localparam int DATA_W = 32;
	localparam int AMT_W = 33;
	localparam int TOUCH_W = 48;
	localparam int WIDX_W = 4;
	localparam int SUM_W = 35;

	typedef enum logic [1:0] {
		OP_READ     = 2'd0,
		OP_SEEK_SET = 2'd1,
		OP_SEEK_END = 2'd2,
		OP_SEEK_CUR = 2'd3
	} op_t;

	localparam logic REG_FILE_LENGTH = 1'b0;
	localparam logic REG_CACHE_SIZE = 1'b1;

endpackage

/* hdl/wrc_div.sv */
// Division of the cache size by a constant through reciprocal multiplication.
// Uses wrc_pkg for the data width; quotient is registered from the stored dividend.
`timescale 1ns / 1ps

module wrc_div #(
	parameter int DIVISOR = 4
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [wrc_pkg::DATA_W-1:0]   dividend,
	output logic                         busy,
	output logic [wrc_pkg::DATA_W-1:0]   quotient
);

	localparam int SHIFT = $clog2(DIVISOR);
	localparam int PROD_W = 2 * wrc_pkg::DATA_W + SHIFT + 1;
	localparam logic [PROD_W-1:0] RECIP =
		((PROD_W'(1) << (wrc_pkg::DATA_W + SHIFT)) + PROD_W'(DIVISOR - 1)) /
		PROD_W'(DIVISOR);

	logic [wrc_pkg::DATA_W-1:0] dividend_q;
	logic                       pend_q;
	logic [wrc_pkg::DATA_W-1:0] quot_q;
	logic [PROD_W-1:0]          prod;

	assign prod = PROD_W'(dividend_q) * RECIP;
	assign busy = pend_q;
	assign quotient = quot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dividend_q <= '0;
			pend_q <= 1'b0;
			quot_q <= '0;
		end else if (start) begin
			dividend_q <= dividend;
			pend_q <= 1'b1;
		end else if (pend_q) begin
			quot_q <= prod[wrc_pkg::DATA_W + SHIFT +: wrc_pkg::DATA_W];
			pend_q <= 1'b0;
		end
	end

endmodule

/* hdl/windowed_read_cache_lru.sv */
// Windowed read cache controller: sequencer, window tags and LRU scan.
// Depends on wrc_pkg and wrc_div.
`timescale 1ns / 1ps

// A seek goes through the seek and clamp steps to the output step, and a read with
// nothing to deliver goes from the check straight to the output step. A chunk read
// passes the check, the tag and LRU scan, which examines one window per cycle
// and stops at the first hit, a refill step on a miss, and the offset, remainder
// and chunk steps before the output step. After a write to cache_size the window
// size is formed by a reciprocal multiplication in the next cycle, and no
// transaction is accepted during that cycle. Results wait in an output register;
// a config write invalidates all windows and rewinds the position.
module windowed_read_cache_lru #(
	parameter int NUM_WINDOWS = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [39:0]  s_axis_tdata,   // amount[32:0], zero pad
	input  logic [1:0]   s_axis_tuser,   // operation[1:0]
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// new_position, chunk_bytes, window_index, window_byte_offset,
	// fill_needed, fill_file_offset, fill_bytes, zero pad
	output logic [167:0] m_axis_tdata,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	localparam int IW = $clog2(NUM_WINDOWS);
	localparam int DW = wrc_pkg::DATA_W;
	localparam int TW = wrc_pkg::TOUCH_W;
	localparam int SW = wrc_pkg::SUM_W;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SEEK,
		ST_CLAMP,
		ST_CHECK,
		ST_SCAN,
		ST_MISS,
		ST_OFFS,
		ST_REM,
		ST_CHUNK,
		ST_OUT
	} state_t;

	state_t                     state_q;
	wrc_pkg::op_t               op_q;
	logic [wrc_pkg::AMT_W-1:0]  amt_q;
	logic [DW-1:0]              len_q;
	logic [DW-1:0]              csize_q;
	logic [DW-1:0]              pos_q;
	logic [DW-1:0]              size_q;
	logic                       whole_q;
	logic [IW-1:0]              idx_q;
	logic [IW-1:0]              lru_q;
	logic [TW-1:0]              lru_t_q;
	logic [IW-1:0]              hit_q;
	logic [DW-1:0]              base_sel_q;
	logic                       fill_q;
	logic [DW-1:0]              fill_off_q;
	logic [DW-1:0]              fill_len_q;
	logic [DW-1:0]              woff_q;
	logic [DW-1:0]              remain_q;
	logic [DW-1:0]              chunk_q;
	logic [SW-1:0]              sum_q;
	logic [TW-1:0]              cnt_q;
	logic                       out_valid_q;
	logic [167:0]               out_data_q;

	logic [NUM_WINDOWS-1:0]     valid_q;
	logic [TW-1:0]              touched_q [NUM_WINDOWS];
	logic [DW-1:0]              base_q [NUM_WINDOWS];

	logic                       cfg_wr;
	logic                       div_busy;
	logic [DW-1:0]              split_size;
	logic                       in_fire;
	logic [SW-1:0]              amt_ext;
	logic [DW-1:0]              base_cur;
	logic [DW-1:0]              pos_rel;
	logic                       hit_now;
	logic                       last_win;
	logic                       lru_take;
	logic [DW-1:0]              top;
	logic [DW-1:0]              base_new;
	logic [IW-1:0]              victim;
	logic [DW-1:0]              chunk_new;

	wrc_div #(
		.DIVISOR(NUM_WINDOWS)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cfg_wr && (paddr[2] == wrc_pkg::REG_CACHE_SIZE)),
		.dividend(pwdata),
		.busy    (div_busy),
		.quotient(split_size)
	);

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == wrc_pkg::REG_CACHE_SIZE) ? csize_q : len_q;

	assign s_axis_tready = (state_q == ST_IDLE) && !div_busy;
	assign in_fire = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = out_data_q;

	assign amt_ext = {{(SW - wrc_pkg::AMT_W){amt_q[wrc_pkg::AMT_W-1]}}, amt_q};

	assign base_cur = base_q[idx_q];
	assign pos_rel = pos_q - base_cur;
	assign hit_now = valid_q[idx_q] && (pos_q >= base_cur) && (pos_rel < size_q);
	assign last_win = whole_q || (idx_q == IW'(NUM_WINDOWS - 1));
	assign lru_take = (idx_q == '0) || (touched_q[idx_q] < lru_t_q);

	assign top = len_q - size_q;
	assign base_new = whole_q ? '0 : ((pos_q < top) ? pos_q : top);
	assign victim = whole_q ? '0 : lru_q;
	assign chunk_new = (amt_q[DW-1:0] < remain_q) ? amt_q[DW-1:0] : remain_q;

	always_ff @(posedge clk) begin
		if (state_q == ST_MISS) begin
			base_q[victim] <= base_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q <= wrc_pkg::OP_READ;
			amt_q <= '0;
			len_q <= '0;
			csize_q <= '0;
			pos_q <= '0;
			size_q <= '0;
			whole_q <= 1'b0;
			idx_q <= '0;
			lru_q <= '0;
			lru_t_q <= '0;
			hit_q <= '0;
			base_sel_q <= '0;
			fill_q <= 1'b0;
			fill_off_q <= '0;
			fill_len_q <= '0;
			woff_q <= '0;
			remain_q <= '0;
			chunk_q <= '0;
			sum_q <= '0;
			cnt_q <= TW'(1);
			out_valid_q <= 1'b0;
			out_data_q <= '0;
			valid_q <= '0;
			for (int i = 0; i < NUM_WINDOWS; i++) begin
				touched_q[i] <= '0;
			end
		end else begin
			if (out_valid_q && m_axis_tready && (state_q != ST_OUT)) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_wr) begin
				if (paddr[2] == wrc_pkg::REG_CACHE_SIZE) begin
					csize_q <= pwdata;
				end else begin
					len_q <= pwdata;
				end
				valid_q <= '0;
				pos_q <= '0;
				for (int i = 0; i < NUM_WINDOWS; i++) begin
					touched_q[i] <= '0;
				end
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						op_q <= wrc_pkg::op_t'(s_axis_tuser);
						amt_q <= s_axis_tdata[wrc_pkg::AMT_W-1:0];
						hit_q <= '0;
						fill_q <= 1'b0;
						fill_off_q <= '0;
						fill_len_q <= '0;
						woff_q <= '0;
						chunk_q <= '0;
						state_q <= (wrc_pkg::op_t'(s_axis_tuser) == wrc_pkg::OP_READ) ?
							ST_CHECK : ST_SEEK;
					end
				end
				ST_SEEK: begin
					case (op_q)
						wrc_pkg::OP_SEEK_SET: sum_q <= amt_ext;
						wrc_pkg::OP_SEEK_END: sum_q <= SW'(len_q) - amt_ext;
						wrc_pkg::OP_SEEK_CUR: sum_q <= SW'(pos_q) + amt_ext;
						default: sum_q <= '0;
					endcase
					state_q <= ST_CLAMP;
				end
				ST_CLAMP: begin
					if (sum_q[SW-1]) begin
						pos_q <= '0;
					end else if (sum_q[SW-2:0] > (SW - 1)'(len_q)) begin
						pos_q <= len_q;
					end else begin
						pos_q <= sum_q[DW-1:0];
					end
					state_q <= ST_OUT;
				end
				ST_CHECK: begin
					if (amt_q[wrc_pkg::AMT_W-1] || (amt_q == '0) || (pos_q >= len_q)) begin
						state_q <= ST_OUT;
					end else begin
						whole_q <= len_q <= csize_q;
						size_q <= (len_q <= csize_q) ? len_q : split_size;
						idx_q <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (hit_now) begin
						hit_q <= idx_q;
						base_sel_q <= base_cur;
						state_q <= ST_OFFS;
					end else begin
						if (lru_take) begin
							lru_q <= idx_q;
							lru_t_q <= touched_q[idx_q];
						end
						if (last_win) begin
							state_q <= ST_MISS;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				ST_MISS: begin
					valid_q[victim] <= 1'b1;
					hit_q <= victim;
					base_sel_q <= base_new;
					fill_q <= 1'b1;
					fill_off_q <= base_new;
					fill_len_q <= size_q;
					state_q <= ST_OFFS;
				end
				ST_OFFS: begin
					woff_q <= pos_q - base_sel_q;
					state_q <= ST_REM;
				end
				ST_REM: begin
					remain_q <= size_q - woff_q;
					state_q <= ST_CHUNK;
				end
				ST_CHUNK: begin
					chunk_q <= chunk_new;
					pos_q <= pos_q + chunk_new;
					touched_q[hit_q] <= cnt_q;
					cnt_q <= cnt_q + 1'b1;
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!out_valid_q || m_axis_tready) begin
						out_valid_q <= 1'b1;
						out_data_q <= {3'b000, fill_len_q, fill_off_q, fill_q, woff_q,
							wrc_pkg::WIDX_W'(hit_q), chunk_q, pos_q};
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
